FILE: rtl/error_diffusion_dither_macros.svh
// assertion macros shared by the error diffusion ditherer checkers
`ifndef ERROR_DIFFUSION_DITHER_MACROS_SVH
`define ERROR_DIFFUSION_DITHER_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define EDD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define EDD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/edd_pkg.sv
// shared types, constants and arithmetic helpers for the error diffusion ditherer
`timescale 1ns / 1ps

package edd_pkg;

  localparam int PIX_W  = 8;
  localparam int CFG_W  = 12;
  localparam int ERR_W  = 9;
  localparam int SHR_W  = 8;
  localparam int PROD_W = ERR_W + 4;
  localparam int SUM_W  = PIX_W + 2;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam int DEF_MAX_WIDTH = 2048;

  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 12'd512;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 12'd512;

  localparam logic [PIX_W-1:0] THRESHOLD = 8'd127;
  localparam logic [PIX_W-1:0] PIX_MAX   = 8'd255;

  localparam int SHARE_DIV   = 16;
  localparam int SHARE_SHIFT = $clog2(SHARE_DIV);

  localparam logic [2:0] SHARE_RIGHT      = 3'd7;
  localparam logic [2:0] SHARE_DOWN_LEFT  = 3'd3;
  localparam logic [2:0] SHARE_DOWN       = 3'd5;
  localparam logic [2:0] SHARE_DOWN_RIGHT = 3'd1;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic {
    MODE_PIXEL = 1'b0,
    MODE_FLUSH = 1'b1
  } mode_t;

  typedef struct packed {
    logic             mode;
    logic [PIX_W-1:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic dither_bit;
    logic last_of_frame;
  } out_item_t;

  // quantizer stage control; pixel low means a drain request
  typedef struct packed {
    logic pixel;
    logic row0;
    logic first;
    logic last;
  } s1_ctl_t;

  // diffusion stage control and payload
  typedef struct packed {
    logic                    row0;
    logic                    first;
    logic                    last;
    logic [PIX_W-1:0]        pix;
    logic signed [ERR_W-1:0] err;
  } s2_ctl_t;

  // err * k / 16, truncated toward zero
  function automatic logic signed [SHR_W-1:0] share_f(input logic signed [ERR_W-1:0] err,
                                                      input logic [2:0] k);
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] adj;
    prod = PROD_W'(err) * $signed({1'b0, k});
    adj  = prod[PROD_W-1] ? prod + PROD_W'(SHARE_DIV - 1) : prod;
    return SHR_W'(adj >>> SHARE_SHIFT);
  endfunction

  function automatic logic [PIX_W-1:0] add_clamp_f(input logic [PIX_W-1:0] base,
                                                   input logic signed [SHR_W-1:0] d);
    logic signed [SUM_W-1:0] sum;
    sum = $signed({2'b00, base}) + SUM_W'(d);
    if (sum < 0) begin
      return '0;
    end else if (sum > $signed({2'b00, PIX_MAX})) begin
      return PIX_MAX;
    end
    return sum[PIX_W-1:0];
  endfunction

endpackage

FILE: rtl/edd_ram.sv
// generic single-write, single-read memory with registered read data
`timescale 1ns / 1ps

module edd_ram #(
  parameter int WIDTH = edd_pkg::PIX_W,
  parameter int DEPTH = edd_pkg::DEF_MAX_WIDTH,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/edd_quant.sv
// quantizer stage: adds the carried right share, thresholds and forms the error
`timescale 1ns / 1ps

module edd_quant (
  input  logic                             clk,
  input  logic                             step,
  input  edd_pkg::s1_ctl_t                 ctl,
  input  logic [edd_pkg::PIX_W-1:0]        rd_data,
  input  logic [edd_pkg::PIX_W-1:0]        row_end_pix,
  output logic                             q_bit,
  output logic signed [edd_pkg::ERR_W-1:0] q_err
);

  logic signed [edd_pkg::SHR_W-1:0] carry_r;
  logic signed [edd_pkg::SHR_W-1:0] carry_nxt;
  logic [edd_pkg::PIX_W-1:0]        base;
  logic [edd_pkg::PIX_W-1:0]        val;

  always_comb begin
    base  = ctl.last ? row_end_pix : rd_data;
    val   = ctl.first ? base : edd_pkg::add_clamp_f(base, carry_r);
    q_bit = val > edd_pkg::THRESHOLD;
    q_err = q_bit ? $signed({1'b0, val}) - $signed({1'b0, edd_pkg::PIX_MAX})
                  : $signed({1'b0, val});
    carry_nxt = step ? edd_pkg::share_f(q_err, edd_pkg::SHARE_RIGHT) : carry_r;
  end

  always_ff @(posedge clk) begin
    carry_r <= carry_nxt;
  end

endmodule

FILE: rtl/edd_spread.sv
// diffusion stage: builds the next row values and writes finished entries back
`timescale 1ns / 1ps

module edd_spread #(
  parameter int MAX_WIDTH = edd_pkg::DEF_MAX_WIDTH,
  localparam int CW       = $clog2(MAX_WIDTH)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      s2_valid,
  input  edd_pkg::s2_ctl_t          ctl,
  input  logic [CW-1:0]             col,
  output logic                      wr_en,
  output logic [CW-1:0]             wr_addr,
  output logic [edd_pkg::PIX_W-1:0] wr_data,
  output logic [edd_pkg::PIX_W-1:0] row_end_pix
);

  logic signed [edd_pkg::SHR_W-1:0] pend_r;
  logic signed [edd_pkg::SHR_W-1:0] pend_nxt;
  logic [edd_pkg::PIX_W-1:0]        prev_r;
  logic [edd_pkg::PIX_W-1:0]        prev_nxt;
  logic [edd_pkg::PIX_W-1:0]        held_r;
  logic [edd_pkg::PIX_W-1:0]        held_nxt;
  logic signed [edd_pkg::ERR_W-1:0] err_eff;
  logic [edd_pkg::PIX_W-1:0]        mixed;
  logic [edd_pkg::PIX_W-1:0]        below;

  always_comb begin
    // the first row is stored as it arrives
    err_eff = ctl.row0 ? '0 : ctl.err;
    mixed   = (ctl.row0 || ctl.first) ? ctl.pix : edd_pkg::add_clamp_f(ctl.pix, pend_r);
    below   = edd_pkg::add_clamp_f(mixed, edd_pkg::share_f(err_eff, edd_pkg::SHARE_DOWN));

    // left neighbor is final once its down-left share is in
    wr_en   = s2_valid && !ctl.first;
    wr_addr = CW'(col - 1'b1);
    wr_data = edd_pkg::add_clamp_f(prev_r,
                                   edd_pkg::share_f(err_eff, edd_pkg::SHARE_DOWN_LEFT));

    pend_nxt = s2_valid ? edd_pkg::share_f(err_eff, edd_pkg::SHARE_DOWN_RIGHT) : pend_r;
    prev_nxt = s2_valid ? below : prev_r;
    held_nxt = (s2_valid && ctl.last) ? below : held_r;
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    prev_r <= prev_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else begin
      held_r <= held_nxt;
    end
  end

  assign row_end_pix = held_r;

endmodule

FILE: rtl/error_diffusion_dither.sv
// error diffusion ditherer top level: one bit per gray pixel, results trail the input by a row
// pipeline: a taken request goes to the quantizer stage register, then to the output register
// throughput: one request per clock at frame widths of four and up while the output is not
//   stalled; below that the line buffer read-after-write interlock can also stall requests
// reset: synchronous active low; counters and pipeline clear, frame returns to 512 x 512,
//   line buffer is not cleared
`timescale 1ns / 1ps

module error_diffusion_dither #(
  parameter int MAX_WIDTH = edd_pkg::DEF_MAX_WIDTH,
  localparam int CW       = $clog2(MAX_WIDTH)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  edd_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output edd_pkg::out_item_t         out_data,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [edd_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [edd_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [edd_pkg::DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  localparam int PAD_W = edd_pkg::DATA_W - edd_pkg::CFG_W;

  logic [edd_pkg::CFG_W-1:0] frame_width_r;
  logic [edd_pkg::CFG_W-1:0] frame_width_nxt;
  logic [edd_pkg::CFG_W-1:0] frame_height_r;
  logic [edd_pkg::CFG_W-1:0] frame_height_nxt;
  logic [CW-1:0]             col_r;
  logic [CW-1:0]             col_nxt;
  logic [edd_pkg::CFG_W-1:0] row_r;
  logic [edd_pkg::CFG_W-1:0] row_nxt;

  logic                      s1_valid_r;
  logic                      s1_valid_nxt;
  edd_pkg::s1_ctl_t          s1_r;
  edd_pkg::s1_ctl_t          s1_nxt;
  logic [CW-1:0]             s1_col_r;
  logic [edd_pkg::PIX_W-1:0] s1_pix_r;
  logic                      s2_valid_r;
  logic                      s2_valid_nxt;
  edd_pkg::s2_ctl_t          s2_r;
  logic [CW-1:0]             s2_col_r;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  edd_pkg::out_item_t        out_data_r;

  logic [CW-1:0]             wm1;
  logic [edd_pkg::CFG_W-1:0] heff;
  logic                      draining;
  logic                      at_first;
  logic                      at_last;
  logic                      works;
  logic                      hold;
  logic                      hazard;
  logic                      accept;
  logic                      take;
  logic                      step;
  logic                      cfg_wr;
  edd_pkg::reg_idx_t         cfg_idx;

  logic [edd_pkg::PIX_W-1:0] rd_data;
  logic                      wr_en;
  logic [CW-1:0]             wr_addr;
  logic [edd_pkg::PIX_W-1:0] wr_data;
  logic [edd_pkg::PIX_W-1:0] row_end_pix;
  logic                      q_bit;
  logic signed [edd_pkg::ERR_W-1:0] q_err;

  // does a writer at wcol touch what a reader at rcol needs
  function automatic logic clash_f(input logic [CW-1:0] wcol, input logic [CW-1:0] rcol,
                                   input logic [CW-1:0] lastc);
    logic rd_held;
    rd_held = rcol == lastc;
    return (rd_held && wcol == lastc) ||
           (!rd_held && wcol != '0 && CW'(wcol - 1'b1) == rcol);
  endfunction

  always_comb begin
    if (frame_width_r == '0) begin
      wm1 = '0;
    end else if (32'(frame_width_r) > MAX_WIDTH) begin
      wm1 = CW'(MAX_WIDTH - 1);
    end else begin
      wm1 = CW'(frame_width_r - 1'b1);
    end
    heff = (frame_height_r == '0) ? edd_pkg::CFG_W'(1) : frame_height_r;
  end

  assign draining = row_r == heff;
  assign at_first = col_r == '0;
  assign at_last  = col_r == wm1;
  assign works    = draining ? (in_data.mode == edd_pkg::MODE_FLUSH)
                             : (in_data.mode == edd_pkg::MODE_PIXEL);
  assign hold     = out_valid_r && out_stall;
  assign hazard   = (s1_valid_r && s1_r.pixel && clash_f(s1_col_r, col_r, wm1)) ||
                    (s2_valid_r && clash_f(s2_col_r, col_r, wm1));
  assign in_stall = hold || hazard;
  assign accept   = in_valid && !in_stall;
  assign take     = accept && works;
  assign step     = !hold && s1_valid_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = edd_pkg::reg_idx_t'(cfg_paddr[edd_pkg::ADDR_W-1]);

  always_comb begin
    case (cfg_idx)
      edd_pkg::REG_FRAME_WIDTH:  cfg_prdata = {{PAD_W{1'b0}}, frame_width_r};
      edd_pkg::REG_FRAME_HEIGHT: cfg_prdata = {{PAD_W{1'b0}}, frame_height_r};
      default:                   cfg_prdata = '0;
    endcase
  end

  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    col_nxt          = col_r;
    row_nxt          = row_r;
    if (cfg_wr) begin
      case (cfg_idx)
        edd_pkg::REG_FRAME_WIDTH:  frame_width_nxt  = cfg_pwdata[edd_pkg::CFG_W-1:0];
        edd_pkg::REG_FRAME_HEIGHT: frame_height_nxt = cfg_pwdata[edd_pkg::CFG_W-1:0];
        default: ;
      endcase
      col_nxt = '0;
      row_nxt = '0;
    end else if (take) begin
      col_nxt = at_last ? '0 : CW'(col_r + 1'b1);
      if (at_last) begin
        row_nxt = draining ? '0 : edd_pkg::CFG_W'(row_r + 1'b1);
      end
    end
  end

  always_comb begin
    s1_valid_nxt  = hold ? s1_valid_r : take;
    s2_valid_nxt  = step && s1_r.pixel;
    out_valid_nxt = hold ? out_valid_r : (s1_valid_r && !(s1_r.pixel && s1_r.row0));
    s1_nxt        = '{pixel: !draining, row0: row_r == '0, first: at_first, last: at_last};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= edd_pkg::RST_FRAME_WIDTH;
      frame_height_r <= edd_pkg::RST_FRAME_HEIGHT;
      col_r          <= '0;
      row_r          <= '0;
      s1_valid_r     <= 1'b0;
      s2_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
      col_r          <= col_nxt;
      row_r          <= row_nxt;
      s1_valid_r     <= s1_valid_nxt;
      s2_valid_r     <= s2_valid_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      s1_r       <= s1_nxt;
      s1_col_r   <= col_r;
      s1_pix_r   <= in_data.pixel;
      s2_r       <= '{row0: s1_r.row0, first: s1_r.first, last: s1_r.last,
                      pix: s1_pix_r, err: q_err};
      s2_col_r   <= s1_col_r;
      out_data_r <= '{dither_bit: q_bit, last_of_frame: !s1_r.pixel && s1_r.last};
    end
  end

  edd_ram #(
    .WIDTH (edd_pkg::PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (take),
    .raddr (col_r),
    .rdata (rd_data)
  );

  edd_quant u_quant (
    .clk         (clk),
    .step        (step),
    .ctl         (s1_r),
    .rd_data     (rd_data),
    .row_end_pix (row_end_pix),
    .q_bit       (q_bit),
    .q_err       (q_err)
  );

  edd_spread #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_spread (
    .clk         (clk),
    .rst_n       (rst_n),
    .s2_valid    (s2_valid_r),
    .ctl         (s2_r),
    .col         (s2_col_r),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .row_end_pix (row_end_pix)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/edd_checker.sv
// port-level assertions for the error diffusion ditherer and their bind
`timescale 1ns / 1ps
`include "error_diffusion_dither_macros.svh"

module edd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input edd_pkg::out_item_t out_data
);

  logic out_held;
  logic in_take;

  assign out_held = out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  `EDD_ASSERT_NEXT(a_out_held, out_held, out_valid && $stable(out_data), "stalled result changed")
  `EDD_ASSERT_NOW(a_no_take_on_full, out_held, in_stall, "request taken while result stalled")
  `EDD_ASSERT_NOW(a_result_source, $rose(out_valid), $past(in_take, 2), "result without request")

endmodule

bind error_diffusion_dither edd_checker u_edd_checker (.*);
